// ===== sv/ptwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwa_pkg
// shared sizes, register indexes and job and result types of the per-tank window average
// ----------------------------------------------------------------------------
package ptwa_pkg;

	localparam int TANK_COUNT  = 10;
	localparam int MAX_WINDOW  = 16;
	localparam int SAMPLE_BITS = 16;

	// fixed field widths of the ports
	localparam int TANK_W   = 4;
	localparam int WEIGHT_W = 16;
	localparam int AVG_W    = 20;
	localparam int VCNT_W   = 5;
	localparam int WLEN_W   = 5;
	localparam int LIMIT_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT  = CFG_IDX_W'(1);
	localparam logic [WLEN_W-1:0]    WLEN_RESET        = WLEN_W'(10);
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET       = LIMIT_W'(8);

	// derived sizes
	localparam int STORE_W = (SAMPLE_BITS < WEIGHT_W) ? SAMPLE_BITS : WEIGHT_W;
	localparam int TIDX_W  = (TANK_COUNT > 1) ? $clog2(TANK_COUNT) : 1;
	localparam int IDX_W   = $clog2(MAX_WINDOW);
	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W  = $clog2(TANK_COUNT * MAX_WINDOW);
	localparam int SUM_W   = STORE_W + IDX_W;
	localparam int FRAC_W  = 4;
	localparam int DVD_W   = SUM_W + FRAC_W;
	localparam int STEP_W  = $clog2(DVD_W);

	typedef struct packed {
		logic [TIDX_W-1:0] tank;
		logic [CNT_W-1:0]  count;
	} ptwa_job_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] sum;
	} ptwa_sum_t;

	typedef struct packed {
		logic             done;
		logic [AVG_W-1:0] quot;
	} ptwa_div_t;

endpackage

// ===== sv/ptwa_accum.sv =====
// ----------------------------------------------------------------------------
// ptwa_accum
// reading store and window summer, one stored reading per cycle
// ----------------------------------------------------------------------------
module ptwa_accum import ptwa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [TIDX_W-1:0]  wr_tank,
	input  logic [IDX_W-1:0]   wr_slot,
	input  logic [STORE_W-1:0] wr_data,
	input  logic               start,
	input  ptwa_job_t          job,
	output ptwa_sum_t          res
);

	logic [STORE_W-1:0] mem [TANK_COUNT*MAX_WINDOW];
	logic [STORE_W-1:0] rd_data_s1;
	logic               rd_vld_s1;
	logic               rd_last_s1;
	logic               busy_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIDX_W-1:0]  tank_q;
	logic [SUM_W-1:0]   acc_q;
	logic               done_q;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic               last_c;

	assign wr_addr = ADDR_W'(wr_tank) * ADDR_W'(MAX_WINDOW) + ADDR_W'(wr_slot);
	assign rd_addr = ADDR_W'(tank_q) * ADDR_W'(MAX_WINDOW) + ADDR_W'(k_q[IDX_W-1:0]);
	assign last_c  = (k_q == cnt_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (busy_q) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			done_q     <= 1'b0;
			k_q        <= '0;
			cnt_q      <= '0;
			tank_q     <= '0;
			acc_q      <= '0;
		end else begin
			rd_vld_s1  <= busy_q;
			rd_last_s1 <= busy_q & last_c;
			done_q     <= rd_vld_s1 & rd_last_s1;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				cnt_q  <= job.count;
				tank_q <= job.tank;
				acc_q  <= '0;
			end else begin
				if (busy_q) begin
					k_q <= k_q + CNT_W'(1);
					if (last_c) begin
						busy_q <= 1'b0;
					end
				end
				if (rd_vld_s1) begin
					acc_q <= acc_q + SUM_W'(rd_data_s1);
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.sum  = acc_q;

endmodule

// ===== sv/ptwa_div.sv =====
// ----------------------------------------------------------------------------
// ptwa_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptwa_div import ptwa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output ptwa_div_t        res
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;
	logic              ge;

	// shift in the next dividend bit, subtract when it fits
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = (rem_sh >= {1'b0, dsr_q});
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			dvd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				dsr_q  <= divisor;
				dvd_q  <= dividend;
			end else if (busy_q) begin
				rem_q  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
				dvd_q  <= {dvd_q[DVD_W-2:0], ge};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = AVG_W'(dvd_q);

endmodule

// ===== sv/per_tank_windowed_weight_average.sv =====
// ----------------------------------------------------------------------------
// per_tank_windowed_weight_average
// per-tank ring of load-cell readings with presence-change clearing; returns
// the mean of the filled entries as unsigned fixed point with 4 fraction bits
// ----------------------------------------------------------------------------
//  channel  | handshake                 | word
//  ---------+---------------------------+----------------------------------------
//  sample   | sample_valid/sample_stall | tank, present, weight
//  result   | result_valid/result_stall | tank_out, average_q4, valid_count,
//           |                           | presence_changed, present_out
//  cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// one sample at a time: the time from accept to result is set by the window sum
// (one store read per cycle) and the 24-step serial divide
// a sample for a tank out of range is taken and dropped, with no result
// the result register lets the next sample in while a word waits on result_stall
// reset clears all tank state; the reading store is never cleared, only
// entries written since the window was last emptied are summed
// ----------------------------------------------------------------------------
module per_tank_windowed_weight_average import ptwa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample channel
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [TANK_W-1:0]    tank,
	input  logic                 present,
	input  logic [WEIGHT_W-1:0]  weight,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [TANK_W-1:0]    tank_out,
	output logic [AVG_W-1:0]     average_q4,
	output logic [VCNT_W-1:0]    valid_count,
	output logic                 presence_changed,
	output logic                 present_out,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]         state_q;

	// configuration registers
	logic [WLEN_W-1:0]  wlen_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               cfg_wr;

	// per-tank state
	logic [IDX_W-1:0]   wpos_q [TANK_COUNT];
	logic               full_q [TANK_COUNT];
	logic               seen_q [TANK_COUNT];

	// job being worked on
	logic [TIDX_W-1:0]  job_tank_q;
	logic [CNT_W-1:0]   job_cnt_q;
	logic               job_chg_q;
	logic               job_pres_q;

	// result register
	logic               out_vld_q;
	logic [TANK_W-1:0]  out_tank_q;
	logic [AVG_W-1:0]   out_avg_q;
	logic [VCNT_W-1:0]  out_cnt_q;
	logic               out_chg_q;
	logic               out_pres_q;

	// accept-cycle window update
	logic               accept;
	logic               in_range;
	logic               take;
	logic [TIDX_W-1:0]  ti;
	logic [CNT_W-1:0]   len_c;
	logic               chg_c;
	logic [CNT_W-1:0]   pos0_c;
	logic [CNT_W-1:0]   pos_raw;
	logic               full0_c;
	logic               full1_c;
	logic [CNT_W-1:0]   pos1_c;
	logic [CNT_W-1:0]   pos_inc;
	logic [CNT_W-1:0]   cnt_c;

	ptwa_job_t          acc_job;
	ptwa_sum_t          sum_res;
	ptwa_div_t          div_res;
	logic               div_start;
	logic               out_free;

	assign accept   = sample_valid & ~sample_stall;
	assign in_range = (int'(tank) < TANK_COUNT);
	assign take     = accept & in_range;
	assign ti       = TIDX_W'(tank);
	assign cfg_ready = 1'b1;
	assign cfg_wr   = cfg_valid & cfg_ready;

	// effective window: zero reads as one, saturate at the store depth
	always_comb begin
		if (wlen_q == '0) begin
			len_c = CNT_W'(1);
		end else if (int'(wlen_q) > MAX_WINDOW) begin
			len_c = CNT_W'(MAX_WINDOW);
		end else begin
			len_c = CNT_W'(wlen_q);
		end
	end

	// presence change empties the window for low-numbered tanks
	assign chg_c   = (tank[LIMIT_W-1:0] < limit_q) && (seen_q[ti] != present);
	assign pos_raw = chg_c ? '0 : CNT_W'(wpos_q[ti]);
	assign pos0_c  = (pos_raw >= len_c) ? '0 : pos_raw;
	assign full0_c = chg_c ? 1'b0 : full_q[ti];
	assign full1_c = full0_c | (pos0_c == len_c - CNT_W'(1));
	assign pos_inc = pos0_c + CNT_W'(1);
	assign pos1_c  = (pos_inc >= len_c) ? '0 : pos_inc;

	// readings in the mean
	always_comb begin
		if (full1_c) begin
			cnt_c = len_c;
		end else if (pos1_c == '0) begin
			cnt_c = CNT_W'(1);
		end else begin
			cnt_c = pos1_c;
		end
	end

	assign acc_job.tank  = ti;
	assign acc_job.count = cnt_c;

	ptwa_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_tank (ti),
		.wr_slot (pos0_c[IDX_W-1:0]),
		.wr_data (weight[STORE_W-1:0]),
		.start   (take),
		.job     (acc_job),
		.res     (sum_res)
	);

	// sum * 16 over count
	assign div_start = (state_q == ST_SUM) && sum_res.done;

	ptwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_res.sum, {FRAC_W{1'b0}}}),
		.divisor  (job_cnt_q),
		.res      (div_res)
	);

	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = ~out_vld_q | ~result_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (sum_res.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// registers and per-tank window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RESET;
			limit_q <= LIMIT_RESET;
			for (int i = 0; i < TANK_COUNT; i++) begin
				wpos_q[i] <= '0;
				full_q[i] <= 1'b0;
				seen_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr && cfg_index == REG_WINDOW_LENGTH) begin
				wlen_q <= cfg_data;
				// new length empties every window, presence is kept
				for (int i = 0; i < TANK_COUNT; i++) begin
					wpos_q[i] <= '0;
					full_q[i] <= 1'b0;
				end
			end else if (take) begin
				wpos_q[ti] <= pos1_c[IDX_W-1:0];
				full_q[ti] <= full1_c;
			end
			if (cfg_wr && cfg_index == REG_CHANGE_LIMIT) begin
				limit_q <= cfg_data[LIMIT_W-1:0];
			end
			if (take) begin
				seen_q[ti] <= present;
			end
		end
	end

	// job fields carried to the result
	always_ff @(posedge clk) begin
		if (take) begin
			job_tank_q <= ti;
			job_cnt_q  <= cnt_c;
			job_chg_q  <= chg_c;
			job_pres_q <= present;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (~result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_tank_q <= TANK_W'(job_tank_q);
			out_avg_q  <= div_res.quot;
			out_cnt_q  <= VCNT_W'(job_cnt_q);
			out_chg_q  <= job_chg_q;
			out_pres_q <= job_pres_q;
		end
	end

	assign result_valid     = out_vld_q;
	assign tank_out         = out_tank_q;
	assign average_q4       = out_avg_q;
	assign valid_count      = out_cnt_q;
	assign presence_changed = out_chg_q;
	assign present_out      = out_pres_q;

endmodule
